>>> hdl/srss_pkg.sv
`timescale 1ns / 1ps

package srss_pkg;

	// Number of switches on the shift register chain.
	localparam int NUM_INPUTS_DEF = 22;
	localparam int NUM_INPUTS_MAX = 32;

	// Positions covered by the fixed control map.
	localparam int MAP_LEN = 22;

	localparam int TICK_W = 16;
	localparam int CHAN_W = 4;
	localparam int CC_W   = 7;
	localparam int TIME_W = 32;
	localparam int SCAN_W = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_CHANNEL = 1'd1;

	localparam logic [TICK_W-1:0] TICK_RESET = 16'd1;
	localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd6;

	localparam logic [CC_W-1:0] CC_VALUE_RISE = 7'd0;
	localparam logic [CC_W-1:0] CC_VALUE_FALL = 7'd127;

	typedef enum logic [1:0] {
		PH_LOAD,
		PH_READ,
		PH_ADVANCE,
		PH_CLEAR
	} phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_time;
		logic              data_in;
	} in_word_t;

	typedef struct packed {
		logic              clock_pin;
		logic              load_pin;
		logic              event_valid;
		logic [CC_W-1:0]   cc_number;
		logic [CC_W-1:0]   cc_value;
		logic [CHAN_W-1:0] channel_out;
		logic [SCAN_W-1:0] scan_count;
	} out_word_t;

	// What the sequencer hands to the event stage for one poll.
	typedef struct packed {
		logic              do_read;
		logic              data;
		logic [CC_W-1:0]   cc_number;
		logic [CHAN_W-1:0] channel;
		logic              clock_pin;
		logic              load_pin;
		logic [SCAN_W-1:0] scan_count;
	} seq_ctl_t;

	// Control number for a switch position; unmapped positions report themselves.
	function automatic logic [CC_W-1:0] cc_map(input logic [CC_W-1:0] pos);
		logic [CC_W-1:0] num;
		unique case (pos)
			7'd0:    num = 7'd10;
			7'd1:    num = 7'd11;
			7'd2:    num = 7'd12;
			7'd3:    num = 7'd13;
			7'd4:    num = 7'd1;
			7'd5:    num = 7'd2;
			7'd6:    num = 7'd3;
			7'd7:    num = 7'd4;
			7'd8:    num = 7'd18;
			7'd9:    num = 7'd19;
			7'd10:   num = 7'd20;
			7'd11:   num = 7'd21;
			7'd12:   num = 7'd9;
			7'd13:   num = 7'd8;
			7'd14:   num = 7'd7;
			7'd15:   num = 7'd0;
			7'd16:   num = 7'd14;
			7'd17:   num = 7'd15;
			7'd18:   num = 7'd16;
			7'd19:   num = 7'd17;
			7'd20:   num = 7'd5;
			7'd21:   num = 7'd6;
			default: num = pos;
		endcase
		return num;
	endfunction

endpackage

>>> hdl/srss_level_ram.sv
`timescale 1ns / 1ps

// Stored switch levels: one read-first port that returns the old level and
// writes the new one in the same cycle. Entries never written read as low.
module srss_level_ram #(
	parameter int DEPTH = srss_pkg::NUM_INPUTS_DEF,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);

	logic             mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic             rd_level_q;
	logic             rd_written_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_level_q <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else if (en) begin
			rd_written_q    <= written_q[addr];
			written_q[addr] <= 1'b1;
		end
	end

	assign rdata = rd_written_q & rd_level_q;

endmodule

>>> hdl/srss_sequencer.sv
`timescale 1ns / 1ps

// Four-phase pin sequencer with the configuration registers.
module srss_sequencer #(
	parameter int NUM_INPUTS = srss_pkg::NUM_INPUTS_DEF,
	parameter int AW         = 5,
	parameter int PW         = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  srss_pkg::in_word_t                 in_word,
	input  logic                               cfg_we,
	input  logic [srss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srss_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               ram_en,
	output logic [AW-1:0]                      ram_addr,
	output srss_pkg::seq_ctl_t                 ctl
);

	localparam logic [PW-1:0] POS_LAST = PW'(NUM_INPUTS - 1);
	localparam logic [PW-1:0] POS_END  = PW'(NUM_INPUTS);

	logic [srss_pkg::TICK_W-1:0] tick_q;
	logic [srss_pkg::CHAN_W-1:0] chan_q;

	srss_pkg::phase_t            phase_q, phase_d;
	logic [PW-1:0]               pos_q, pos_d;
	logic [srss_pkg::TIME_W-1:0] last_q, last_d;
	logic                        half_q, half_d;
	logic [srss_pkg::SCAN_W-1:0] scans_q, scans_d;
	logic                        clk_lvl_q, clk_lvl_d;
	logic                        load_lvl_q, load_lvl_d;

	logic [srss_pkg::TIME_W-1:0] elapsed;
	logic                        due0;
	logic                        due1;
	logic                        load_go;
	logic                        read_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= srss_pkg::TICK_RESET;
			chan_q <= srss_pkg::CHAN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srss_pkg::REG_TICK_INTERVAL: tick_q <= cfg_data[srss_pkg::TICK_W-1:0];
				srss_pkg::REG_EVENT_CHANNEL: chan_q <= cfg_data[srss_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign elapsed = in_word.now_time - last_q;
	assign due0    = elapsed >= {{(srss_pkg::TIME_W - srss_pkg::TICK_W){1'b0}}, tick_q};
	assign load_go = (phase_q == srss_pkg::PH_LOAD) && due0;
	// Once the load tick is taken in this poll, no time has passed since.
	assign due1    = load_go ? (tick_q == '0) : due0;
	assign read_go = (phase_q == srss_pkg::PH_READ) || load_go;

	// Next state: the phases are evaluated in order within one poll.
	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		last_d     = last_q;
		half_d     = half_q;
		scans_d    = scans_q;
		clk_lvl_d  = clk_lvl_q;
		load_lvl_d = load_lvl_q;
		if (load_go) begin
			clk_lvl_d  = 1'b0;
			load_lvl_d = 1'b1;
			last_d     = in_word.now_time;
			phase_d    = srss_pkg::PH_READ;
		end
		if (phase_d == srss_pkg::PH_READ) begin
			phase_d = (pos_q >= POS_LAST) ? srss_pkg::PH_CLEAR : srss_pkg::PH_ADVANCE;
			pos_d   = pos_q + PW'(1);
		end
		if (phase_d == srss_pkg::PH_ADVANCE && due1) begin
			clk_lvl_d = half_q;
			last_d    = in_word.now_time;
			half_d    = ~half_q;
			phase_d   = half_q ? srss_pkg::PH_READ : srss_pkg::PH_ADVANCE;
		end
		if (phase_d == srss_pkg::PH_CLEAR && due1) begin
			clk_lvl_d  = 1'b0;
			load_lvl_d = 1'b0;
			last_d     = in_word.now_time;
			pos_d      = '0;
			phase_d    = srss_pkg::PH_LOAD;
			scans_d    = scans_q + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= srss_pkg::PH_LOAD;
			pos_q      <= '0;
			last_q     <= '0;
			half_q     <= 1'b0;
			scans_q    <= '0;
			clk_lvl_q  <= 1'b0;
			load_lvl_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			last_q     <= last_d;
			half_q     <= half_d;
			scans_q    <= scans_d;
			clk_lvl_q  <= clk_lvl_d;
			load_lvl_q <= load_lvl_d;
		end
	end

	// Outputs of the poll.
	always_comb begin
		ram_en         = accept && read_go && (pos_q < POS_END);
		ram_addr       = pos_q[AW-1:0];
		ctl.do_read    = read_go && (pos_q < POS_END);
		ctl.data       = in_word.data_in;
		ctl.cc_number  = srss_pkg::cc_map(srss_pkg::CC_W'(pos_q));
		ctl.channel    = chan_q;
		ctl.clock_pin  = clk_lvl_d;
		ctl.load_pin   = load_lvl_d;
		ctl.scan_count = scans_d;
	end

endmodule

>>> hdl/srss_event_stage.sv
`timescale 1ns / 1ps

// Edge compare against the stored level, and the output register.
module srss_event_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  srss_pkg::seq_ctl_t  ctl,
	input  logic                old_level,
	input  logic                out_stall,
	output logic                in_stall,
	output logic                out_valid,
	output srss_pkg::out_word_t out_word
);

	logic                s1_valid_q;
	srss_pkg::seq_ctl_t  ctl_s1;
	logic                out_valid_q;
	srss_pkg::out_word_t word_s2;
	srss_pkg::out_word_t word_d;
	logic                advance;
	logic                edge_seen;

	assign advance  = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;

	assign edge_seen = ctl_s1.do_read && (ctl_s1.data != old_level);

	always_comb begin
		word_d.clock_pin   = ctl_s1.clock_pin;
		word_d.load_pin    = ctl_s1.load_pin;
		word_d.scan_count  = ctl_s1.scan_count;
		word_d.event_valid = edge_seen;
		word_d.cc_number   = edge_seen ? ctl_s1.cc_number : '0;
		word_d.cc_value    = !edge_seen ? '0 :
			(ctl_s1.data ? srss_pkg::CC_VALUE_RISE : srss_pkg::CC_VALUE_FALL);
		word_d.channel_out = edge_seen ? ctl_s1.channel : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl;
		end
		if (advance) begin
			word_s2 <= word_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = word_s2;

endmodule

>>> hdl/shift_register_switch_scanner_unit.sv
`timescale 1ns / 1ps

// Shift register switch scanner. Each input word is one poll: the current time and the serial
// data bit read from a parallel-in serial-out switch chain. A load / read / advance / clear
// sequencer paces the clock and shift/load pins by tick_interval (register 0, reset 1) and, on
// every read, compares the switch at the current position with its stored level; an edge gives
// a control-change event with the mapped control number, value 0 on a rise and 127 on a fall,
// and event_channel (register 1, reset 6). Exactly one output word follows every input word,
// carrying the pin levels after the poll and the count of completed scans. One poll is taken
// every clock cycle; an accepted word passes the first stage to the output register, and the
// input is held back only while both stages are full and the output is stalled. The rate is
// set by the single read-first port of the switch level memory, which returns the old level
// and writes the new one for the same switch in the same cycle. Stored levels start low after
// reset; per-switch written bits stand in for a clearing pass, so the block is ready at once.
module shift_register_switch_scanner_unit #(
	parameter int NUM_INPUTS = srss_pkg::NUM_INPUTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  srss_pkg::in_word_t              in_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output srss_pkg::out_word_t             out_word,
	input  logic                            cfg_we,
	input  logic [srss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srss_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Memory address width and the width of the read position, which must also hold the
	// count of switches itself once the last one has been read.
	localparam int AW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int PW = $clog2(NUM_INPUTS + 1);

	logic               accept;
	logic               ram_en;
	logic [AW-1:0]      ram_addr;
	logic               old_level;
	srss_pkg::seq_ctl_t ctl;

	assign accept = in_valid && !in_stall;

	srss_sequencer #(
		.NUM_INPUTS (NUM_INPUTS),
		.AW         (AW),
		.PW         (PW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_word   (in_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ram_en    (ram_en),
		.ram_addr  (ram_addr),
		.ctl       (ctl)
	);

	// The poll's data bit is written back while the old level is read out.
	srss_level_ram #(
		.DEPTH (NUM_INPUTS),
		.AW    (AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (ram_en),
		.addr   (ram_addr),
		.wdata  (in_word.data_in),
		.rdata  (old_level)
	);

	srss_event_stage u_evt (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.ctl       (ctl),
		.old_level (old_level),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

`ifndef SYNTHESIS
	// Input is only held back when both stages are full.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output register empty");

	// Without an event the event fields are all zero.
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.event_valid) |->
			(out_word.cc_number == '0 && out_word.cc_value == '0 &&
			 out_word.channel_out == '0))
		else $error("event fields set without an event");

	// The load pin falls only in the clear phase, which completes a scan.
	a_scan_on_load_fall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid) && $fell(out_word.load_pin)) |->
			(out_word.scan_count == $past(out_word.scan_count) + 32'd1))
		else $error("load pin fell without a completed scan");

	// The scan count moves only when the load pin is driven low.
	a_scan_with_load_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid) &&
		 out_word.scan_count != $past(out_word.scan_count)) |-> !out_word.load_pin)
		else $error("scan count moved with load pin high");
`endif

endmodule

>>> test/shift_register_switch_scanner_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the switch chain scanner. A short stimulus table opens the run:
// polls around reset, time wrap-around, a zero and a maximal tick interval, and both extremes of
// the channel register. Randomised phases follow, each with its own register setting. Every
// accepted input word is run through a local copy of the load / read / advance / clear
// sequencer, and the word that it gives is queued. Each output word taken from the block is
// compared, field by field, with the oldest queued word.
module shift_register_switch_scanner_unit_test;
	import srss_pkg::*;

	localparam int NUM_SW         = NUM_INPUTS_DEF;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int RAND_PER_PHASE = 148;
	localparam int NUM_PHASES     = 9;
	// The receiver stops taking words once, for a long while, after this many words.
	localparam int HOLD_AT        = 500;
	localparam int HOLD_CYCLES    = 300;

	typedef enum logic {
		ROW_POLL,
		ROW_CFG
	} row_kind_t;

	// One line of the opening stimulus table. A poll line may carry an expected word typed in
	// by hand; all other poll lines are checked against the sequencer copy.
	typedef struct {
		row_kind_t             kind;
		in_word_t              word;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		bit                    typed;
		out_word_t             want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_word_t              in_word = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_word;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Local copy of the scanner: registers, sequencer and stored switch levels.
	logic [TICK_W-1:0] tick_reg = TICK_RESET;
	logic [CHAN_W-1:0] chan_reg = CHAN_RESET;
	phase_t            seq_phase = PH_LOAD;
	int unsigned       read_pos = 0;
	logic [TIME_W-1:0] tick_stamp = '0;
	logic              half_clk = 1'b0;
	logic [SCAN_W-1:0] scan_total = '0;
	logic              sw_level [NUM_SW];
	logic              clk_level = 1'b0;
	logic              ld_level = 1'b0;

	// Control numbers for each position of the chain.
	logic [CC_W-1:0] ctl_map [MAP_LEN] = '{
		7'd10, 7'd11, 7'd12, 7'd13, 7'd1, 7'd2, 7'd3, 7'd4, 7'd18, 7'd19, 7'd20,
		7'd21, 7'd9, 7'd8, 7'd7, 7'd0, 7'd14, 7'd15, 7'd16, 7'd17, 7'd5, 7'd6
	};

	out_word_t   pending_words [$];
	int          bad_words = 0;
	int unsigned cycle_count = 0;
	int unsigned send_quiet = 0;

	shift_register_switch_scanner_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The watchdog: a correct run ends long before this count.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Wait before the next word. Now and then a stretch of words goes through with no
	// waiting at all, so that back-to-back traffic is seen as well as scattered gaps.
	function automatic int unsigned pick_wait(inout int unsigned quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// A pin change is due once the time since the last one, taken modulo 2^32, has reached
	// the tick interval. A zero interval is therefore always due.
	function automatic bit tick_due(input logic [TIME_W-1:0] now_t);
		logic [TIME_W-1:0] gone;
		gone = now_t - tick_stamp;
		return gone >= TIME_W'(tick_reg);
	endfunction

	// Runs one poll through the sequencer copy and gives the word the block should return.
	// The phases are tried in order, so a single poll may load, read and advance at once.
	function automatic out_word_t scan_poll(input in_word_t w);
		out_word_t r;
		r = '0;
		if (seq_phase == PH_LOAD && tick_due(w.now_time)) begin
			clk_level = 1'b0;
			ld_level = 1'b1;
			tick_stamp = w.now_time;
			seq_phase = PH_READ;
		end
		if (seq_phase == PH_READ) begin
			if (read_pos < NUM_SW) begin
				if (w.data_in != sw_level[read_pos]) begin
					r.event_valid = 1'b1;
					r.cc_number = (read_pos < MAP_LEN) ? ctl_map[read_pos] : CC_W'(read_pos);
					r.cc_value = w.data_in ? CC_VALUE_RISE : CC_VALUE_FALL;
					r.channel_out = chan_reg;
				end
				sw_level[read_pos] = w.data_in;
			end
			seq_phase = (read_pos >= NUM_SW - 1) ? PH_CLEAR : PH_ADVANCE;
			read_pos++;
		end
		if (seq_phase == PH_ADVANCE && tick_due(w.now_time)) begin
			clk_level = half_clk;
			tick_stamp = w.now_time;
			half_clk = ~half_clk;
			seq_phase = half_clk ? PH_ADVANCE : PH_READ;
		end
		if (seq_phase == PH_CLEAR && tick_due(w.now_time)) begin
			clk_level = 1'b0;
			ld_level = 1'b0;
			tick_stamp = w.now_time;
			read_pos = 0;
			seq_phase = PH_LOAD;
			scan_total++;
		end
		r.clock_pin = clk_level;
		r.load_pin = ld_level;
		r.scan_count = scan_total;
		return r;
	endfunction

	function automatic plan_row_t poll_row(input logic [TIME_W-1:0] t, input logic d,
		input bit typed, input out_word_t want);
		plan_row_t row;
		row = '{kind: ROW_POLL, word: '0, reg_index: '0, reg_value: '0, typed: typed,
			want: want};
		row.word.now_time = t;
		row.word.data_in = d;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = '{kind: ROW_CFG, word: '0, reg_index: idx, reg_value: val, typed: 1'b0,
			want: '0};
		return row;
	endfunction

	// Offers one poll after a random gap, holds it until the block takes it, and queues the
	// word it should produce. A typed word replaces the predicted one, though the sequencer
	// copy still steps so that its state stays in line with the block.
	task automatic send_poll(input in_word_t w, input bit typed, input out_word_t want);
		int unsigned gap;
		out_word_t guess;
		gap = pick_wait(send_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
		guess = scan_poll(w);
		pending_words.push_back(typed ? want : guess);
	endtask

	// Registers change only with the block idle: the sender stops and waits until every
	// queued word has come back before the write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TICK_INTERVAL)
			tick_reg = val[TICK_W-1:0];
		else
			chan_reg = val[CHAN_W-1:0];
	endtask

	// Takes output words after random stalls. Once in the run it stops for a long stretch
	// while the sender keeps offering, so that the block fills up and stalls its input.
	initial begin : take_words
		int unsigned quiet;
		int unsigned hold;
		int unsigned taken;
		quiet = 0;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == HOLD_AT)
				hold = HOLD_CYCLES;
			else
				hold = pick_wait(quiet);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Compares each word taken from the block with the oldest queued word.
	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected output word %h", out_word);
			end else begin
				want = pending_words.pop_front();
				if (out_word.clock_pin !== want.clock_pin ||
					out_word.load_pin !== want.load_pin ||
					out_word.event_valid !== want.event_valid ||
					out_word.cc_number !== want.cc_number ||
					out_word.cc_value !== want.cc_value ||
					out_word.channel_out !== want.channel_out ||
					out_word.scan_count !== want.scan_count) begin
					bad_words++;
					if (bad_words <= 10) begin
						$display("mismatch: want clk=%b ld=%b ev=%b cc=%0d val=%0d ch=%0d scans=%0d",
							want.clock_pin, want.load_pin, want.event_valid, want.cc_number,
							want.cc_value, want.channel_out, want.scan_count);
						$display("          got  clk=%b ld=%b ev=%b cc=%0d val=%0d ch=%0d scans=%0d",
							out_word.clock_pin, out_word.load_pin, out_word.event_valid,
							out_word.cc_number, out_word.cc_value, out_word.channel_out,
							out_word.scan_count);
					end
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t         plan [$];
		out_word_t         first_rise;
		in_word_t          w;
		logic [TICK_W-1:0] tick_val;
		logic [CHAN_W-1:0] chan_val;
		int unsigned       one_pct;
		logic [TIME_W-1:0] poll_time;

		foreach (sw_level[i])
			sw_level[i] = 1'b0;

		// After reset the tick interval is one and the last tick sits at time zero, so a poll
		// at time zero does nothing, and a poll at time one loads the chain and reads the first
		// switch high: a rise on the first control number, reported on the reset channel.
		first_rise = '0;
		first_rise.load_pin = 1'b1;
		first_rise.event_valid = 1'b1;
		first_rise.cc_number = 7'd10;
		first_rise.cc_value = CC_VALUE_RISE;
		first_rise.channel_out = CHAN_RESET;

		plan.push_back(poll_row(32'h0000_0000, 1'b0, 1'b1, '0));
		plan.push_back(poll_row(32'h0000_0001, 1'b1, 1'b1, first_rise));
		// Time runs to its top and wraps round to zero.
		plan.push_back(poll_row(32'hFFFF_FFFF, 1'b0, 1'b0, '0));
		plan.push_back(poll_row(32'h0000_0000, 1'b1, 1'b0, '0));
		plan.push_back(poll_row(32'h0000_0000, 1'b0, 1'b0, '0));
		// With a zero interval every pin change is due at once. The upper bits of the channel
		// write fall away, leaving channel zero.
		plan.push_back(cfg_row(REG_TICK_INTERVAL, 16'h0000));
		plan.push_back(cfg_row(REG_EVENT_CHANNEL, 16'hFFF0));
		plan.push_back(poll_row(32'h8000_0000, 1'b1, 1'b0, '0));
		plan.push_back(poll_row(32'h7FFF_FFFF, 1'b0, 1'b0, '0));
		plan.push_back(poll_row(32'h5555_5555, 1'b1, 1'b0, '0));
		plan.push_back(poll_row(32'hAAAA_AAAA, 1'b0, 1'b0, '0));
		plan.push_back(poll_row(32'h0000_0000, 1'b1, 1'b0, '0));
		plan.push_back(poll_row(32'h0000_0000, 1'b1, 1'b0, '0));
		plan.push_back(poll_row(32'hFFFF_FFFE, 1'b0, 1'b0, '0));
		plan.push_back(poll_row(32'h0000_0001, 1'b1, 1'b0, '0));
		// The longest interval, with polls just short of it, on it and across the wrap.
		plan.push_back(cfg_row(REG_TICK_INTERVAL, 16'hFFFF));
		plan.push_back(cfg_row(REG_EVENT_CHANNEL, 16'h000F));
		plan.push_back(poll_row(32'h0001_0000, 1'b0, 1'b0, '0));
		plan.push_back(poll_row(32'h0001_FFFE, 1'b1, 1'b0, '0));
		plan.push_back(poll_row(32'h0002_0000, 1'b0, 1'b0, '0));
		plan.push_back(poll_row(32'hFFFF_0000, 1'b1, 1'b0, '0));
		plan.push_back(poll_row(32'h0000_FFFF, 1'b0, 1'b0, '0));
		plan.push_back(poll_row(32'h0001_0001, 1'b1, 1'b0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].reg_index, plan[i].reg_value);
			else
				send_poll(plan[i].word, plan[i].typed, plan[i].want);
		end

		// Random phases. Time mostly moves forward by up to about twice the interval, so that
		// pin changes are due on some polls and not on others; now and then it stands still or
		// jumps to any value. The share of high data bits differs from phase to phase, from
		// chains that are mostly low to chains that are mostly high.
		poll_time = 32'h0001_0001;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					tick_val = 16'd1;
					chan_val = 4'd15;
					one_pct = 50;
				end
				1: begin
					tick_val = 16'd0;
					chan_val = 4'd0;
					one_pct = 20;
				end
				2: begin
					tick_val = 16'hFFFF;
					chan_val = CHAN_W'($urandom_range(0, 15));
					one_pct = 50;
					poll_time = 32'hFFF8_0000;
				end
				3: begin
					tick_val = TICK_W'($urandom_range(2, 12));
					chan_val = 4'd6;
					one_pct = 80;
				end
				4: begin
					tick_val = 16'd0;
					chan_val = CHAN_W'($urandom_range(0, 15));
					one_pct = 50;
				end
				5: begin
					tick_val = TICK_W'($urandom_range(0, 65535));
					chan_val = 4'd15;
					one_pct = 50;
				end
				6: begin
					tick_val = 16'd1;
					chan_val = 4'd0;
					one_pct = 5;
				end
				7: begin
					tick_val = TICK_W'($urandom_range(1, 4));
					chan_val = CHAN_W'($urandom_range(0, 15));
					one_pct = 95;
				end
				default: begin
					tick_val = 16'hFFFF;
					chan_val = CHAN_W'($urandom_range(0, 15));
					one_pct = 50;
				end
			endcase
			write_reg(REG_TICK_INTERVAL, tick_val);
			write_reg(REG_EVENT_CHANNEL, {12'($urandom_range(0, 4095)), chan_val});
			repeat (RAND_PER_PHASE) begin
				case ($urandom_range(0, 19))
					0: poll_time = $urandom;
					1: poll_time = poll_time;
					default: poll_time = poll_time + $urandom_range(0, 2 * int'(tick_val) + 1);
				endcase
				w.now_time = poll_time;
				w.data_in = ($urandom_range(0, 99) < one_pct);
				send_poll(w, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (bad_words == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> shift_register_switch_scanner_unit.f
hdl/srss_pkg.sv
hdl/srss_level_ram.sv
hdl/srss_sequencer.sv
hdl/srss_event_stage.sv
hdl/shift_register_switch_scanner_unit.sv
test/shift_register_switch_scanner_unit_test.sv
